// ----- src/pdq_pkg.sv -----
// Package for the pid deque: item types, opcodes, status codes and cell controls.
package pdq_pkg;

  // Width of the pid field on the ports.
  localparam int PID_FIELD_W = 16;
  // Width of the occupancy field on the ports.
  localparam int OCC_FIELD_W = 5;

  // Operations carried by an input item.
  typedef enum logic [1:0] {
    OP_PUSH_HEAD = 2'd0,
    OP_PUSH_TAIL = 2'd1,
    OP_POP_HEAD  = 2'd2,
    OP_REMOVE    = 2'd3
  } op_t;

  // Status reported with every result item.
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // What one cell loads at the next clock edge.
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LEFT  = 2'd1,
    CELL_RIGHT = 2'd2,
    CELL_PID   = 2'd3
  } cell_op_t;

  // One input item.
  typedef struct packed {
    op_t                    opcode;
    logic [PID_FIELD_W-1:0] pid;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [PID_FIELD_W-1:0] popped_pid;
    status_t                status;
    logic [OCC_FIELD_W-1:0] occupancy;
  } out_item_t;

endpackage

// ----- src/pdq_cell.sv -----
// One cell of the deque row: holds one pid and compares it with the search key.
module pdq_cell #(
  parameter int W = 16
) (
  input  logic             clk,
  input  pdq_pkg::cell_op_t op,
  input  logic [W-1:0]     left,
  input  logic [W-1:0]     right,
  input  logic [W-1:0]     pid,
  input  logic             occupied,
  output logic [W-1:0]     data,
  output logic             hit
);
  import pdq_pkg::*;

  // Load from the neighbor toward the head, toward the tail, or the new pid, or hold.
  always_ff @(posedge clk) begin
    case (op)
      CELL_LEFT:  data <= left;
      CELL_RIGHT: data <= right;
      CELL_PID:   data <= pid;
      CELL_HOLD:  data <= data;
      default:    data <= data;
    endcase
  end

  // A stored pid matches the key only when this cell is in use.
  assign hit = occupied && (data == pid);

endmodule

// ----- src/pid_deque_with_remove.sv -----
// Top level of the pid deque: a row of cells with shared control and an output register.
// A bounded ordered queue of process ids held in a row of DEPTH cells, head at cell 0.
// Every accepted item (push at head, push at tail, pop head, remove by pid) yields one
// result item in the next cycle, and a new item is taken in every cycle unless a result
// is waiting and the output side stalls. All cells shift toward the head or the tail in
// the same cycle, and a remove finds the first matching cell across the whole row with
// one wide subtract over the match vector. Only the low PID_BITS bits of a pid (at most
// 16) are stored and compared. The occupancy field carries the low five bits of the
// stored count. No clearing pass follows reset.
module pid_deque_with_remove #(
  parameter int DEPTH    = 16,
  parameter int PID_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  pdq_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output pdq_pkg::out_item_t out_item
);
  import pdq_pkg::*;

  localparam int SW = (PID_BITS < PID_FIELD_W) ? PID_BITS : PID_FIELD_W;
  localparam int CW = $clog2(DEPTH + 1);

  logic              in_accept;
  logic [SW-1:0]     key;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic              full;
  logic              empty;
  logic [DEPTH-1:0]  hits;
  logic [DEPTH-1:0]  occupied;
  logic [DEPTH-1:0]  hits_less;
  logic [DEPTH-1:0]  upto_first;
  logic [DEPTH-1:0]  first_hit;
  logic [DEPTH-1:0]  shift_mask;
  logic              found;
  logic [SW-1:0]     cell_data [DEPTH];
  logic [SW-1:0]     left_in   [DEPTH];
  logic [SW-1:0]     right_in  [DEPTH];
  cell_op_t          cell_ops  [DEPTH];
  out_item_t         result;
  logic [CW+OCC_FIELD_W-1:0] count_wide;

  // Handshake: a new item enters unless a result waits on a stalled output.
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign key       = in_item.pid[SW-1:0];
  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);

  // Neighbor wiring and the in-use mask of each cell.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      left_in[i]  = (i == 0) ? key : cell_data[(i == 0) ? 0 : i - 1];
      right_in[i] = (i == DEPTH - 1) ? cell_data[i] : cell_data[(i == DEPTH - 1) ? i : i + 1];
      occupied[i] = (count > CW'(i));
    end
  end

  // First match from the head: the lowest set bit of the match vector.
  assign hits_less  = hits - {{(DEPTH-1){1'b0}}, 1'b1};
  assign upto_first = hits ^ hits_less;
  assign first_hit  = hits & ~hits_less;
  assign shift_mask = ~upto_first | first_hit;
  assign found      = |hits;

  // Per-cell load selection for the accepted item.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_ops[i] = CELL_HOLD;
      if (in_accept) begin
        case (in_item.opcode)
          OP_PUSH_HEAD: if (!full) cell_ops[i] = CELL_LEFT;
          OP_PUSH_TAIL: if (!full && count == CW'(i)) cell_ops[i] = CELL_PID;
          OP_POP_HEAD:  if (!empty) cell_ops[i] = CELL_RIGHT;
          OP_REMOVE:    if (found && shift_mask[i]) cell_ops[i] = CELL_RIGHT;
          default:      cell_ops[i] = CELL_HOLD;
        endcase
      end
    end
  end

  // The row of cells.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    pdq_cell #(.W(SW)) u_cell (
      .clk      (clk),
      .op       (cell_ops[g]),
      .left     (left_in[g]),
      .right    (right_in[g]),
      .pid      (key),
      .occupied (occupied[g]),
      .data     (cell_data[g]),
      .hit      (hits[g])
    );
  end

  // Result and next count for the item on the input.
  always_comb begin
    count_next        = count;
    result.popped_pid = '0;
    result.status     = ST_DONE;
    case (in_item.opcode)
      OP_PUSH_HEAD, OP_PUSH_TAIL: begin
        if (full) result.status = ST_FULL;
        else count_next = count + 1'b1;
      end
      OP_POP_HEAD: begin
        if (empty) begin
          result.status = ST_EMPTY;
        end else begin
          result.popped_pid = PID_FIELD_W'(cell_data[0]);
          count_next        = count - 1'b1;
        end
      end
      OP_REMOVE: begin
        if (!found) result.status = ST_EMPTY;
        else count_next = count - 1'b1;
      end
      default: count_next = count;
    endcase
    count_wide       = {{OCC_FIELD_W{1'b0}}, count_next};
    result.occupancy = count_wide[OCC_FIELD_W-1:0];
  end

  // Stored count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (in_accept) begin
      count <= count_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_item <= result;
    end
  end

endmodule

// ----- src/pdq_checker.sv -----
// Port-level checks for the pid deque and the bind that attaches them.
module pdq_checker #(
  parameter int DEPTH = 16
) (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input pdq_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_stall,
  input pdq_pkg::out_item_t out_item
);
  import pdq_pkg::*;

  localparam logic [OCC_FIELD_W-1:0] FULL_OCC = OCC_FIELD_W'(DEPTH);

  // A waiting result holds while the output stalls.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  // Every accepted item produces a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted item gave no result");

  // A dropped push is only reported when the store is full.
  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status == ST_FULL |-> out_item.occupancy == FULL_OCC)
    else $error("full status with store not full");

  // A popped pid is only shown with a successful status.
  a_pop_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.popped_pid != '0 |-> out_item.status == ST_DONE)
    else $error("nonzero popped pid without success");

  // No result is offered right after reset.
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind pid_deque_with_remove pdq_checker #(.DEPTH(DEPTH)) u_pdq_checker (.*);

// ----- verif/pid_deque_with_remove_tb.sv -----
// Self-checking testbench for the pid deque with a ready-list scoreboard and random traffic.
`timescale 1ns / 100ps

module testbench;
  import pdq_pkg::*;

  // Tracks the stored pids and the results that the block still owes.
  class ready_list_scoreboard;
    localparam int LIST_DEPTH = 16;

    logic [PID_FIELD_W-1:0] held_pids[$];
    out_item_t              expected_results[$];
    int unsigned            errors;

    // Prints one line per mismatch and counts it.
    task report(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      errors++;
    endtask

    // Applies one accepted command to the ready list and queues its result.
    function void note_command(in_item_t cmd);
      out_item_t res;
      int        hit;
      res = '0;
      res.status = ST_DONE;
      hit = -1;
      case (cmd.opcode)
        OP_PUSH_HEAD: begin
          if (held_pids.size() >= LIST_DEPTH) res.status = ST_FULL;
          else held_pids.push_front(cmd.pid);
        end
        OP_PUSH_TAIL: begin
          if (held_pids.size() >= LIST_DEPTH) res.status = ST_FULL;
          else held_pids.push_back(cmd.pid);
        end
        OP_POP_HEAD: begin
          if (held_pids.size() == 0) res.status = ST_EMPTY;
          else res.popped_pid = held_pids.pop_front();
        end
        default: begin
          // Only the match nearest the head is deleted.
          foreach (held_pids[i]) begin
            if (hit < 0 && held_pids[i] == cmd.pid) hit = i;
          end
          if (hit < 0) res.status = ST_EMPTY;
          else held_pids.delete(hit);
        end
      endcase
      res.occupancy = OCC_FIELD_W'(held_pids.size());
      expected_results.push_back(res);
    endfunction

    // Compares one result item with the oldest outstanding expectation.
    task check_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("result %0h with nothing outstanding", got));
        return;
      end
      want = expected_results.pop_front();
      if (got.popped_pid !== want.popped_pid)
        report($sformatf("popped_pid %0h, predicted %0h", got.popped_pid, want.popped_pid));
      if (got.status !== want.status)
        report($sformatf("status %0d, predicted %0d", got.status, want.status));
      if (got.occupancy !== want.occupancy)
        report($sformatf("occupancy %0d, predicted %0d", got.occupancy, want.occupancy));
    endtask
  endclass

  localparam int LIST_DEPTH  = 16;
  localparam int STUCK_LIMIT = 2000;
  localparam int SEGMENTS    = 19;
  localparam int SEG_ITEMS   = 100;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  ready_list_scoreboard ledger = new;

  bit          source_idling;
  bit          sink_idling;
  int unsigned stall_left;
  int unsigned stuck_cycles;

  pid_deque_with_remove #(
    .DEPTH    (LIST_DEPTH),
    .PID_BITS (PID_FIELD_W)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Output side: stalls in random bursts while sink idling is enabled.
  initial stall_left = 0;
  always @(posedge clk) begin
    if (stall_left == 0 && sink_idling && $urandom_range(0, 7) == 0)
      stall_left = $urandom_range(1, 13);
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Handshake monitor and watchdog on cycles with no item moving.
  initial stuck_cycles = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) ledger.note_command(in_item);
      if (out_valid && !out_stall) ledger.check_result(out_item);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles == STUCK_LIMIT) begin
          $display("pid_deque_with_remove verification failed");
          $finish;
        end
      end
    end
  end

  function automatic in_item_t make_cmd(op_t op, logic [PID_FIELD_W-1:0] pid);
    in_item_t cmd;
    cmd.opcode = op;
    cmd.pid = pid;
    return cmd;
  endfunction

  // Offers one item, possibly after an idle burst, and returns once it is taken.
  task automatic send_item(input in_item_t cmd);
    int unsigned gap;
    if (source_idling && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 13);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= cmd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Holds the input side off until every outstanding result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (ledger.expected_results.size() != 0) @(posedge clk);
  endtask

  // Stimulus: directed corner cases, then segments of biased random commands.
  initial begin
    logic [PID_FIELD_W-1:0] pid_pool[6];
    logic [PID_FIELD_W-1:0] pid;
    op_t                    op;
    int unsigned            trend;
    int unsigned            roll;
    int unsigned            push_share;
    int unsigned            pop_share;
    bit                     quiet;

    rst <= 1'b1;
    in_valid <= 1'b0;
    in_item <= '0;
    source_idling = 1'b1;
    sink_idling = 1'b1;
    foreach (pid_pool[i]) pid_pool[i] = PID_FIELD_W'($urandom_range(0, 65535));
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Empty list: pop and remove both report empty.
    send_item(make_cmd(OP_POP_HEAD, 16'h0000));
    send_item(make_cmd(OP_REMOVE, 16'h1234));
    // A duplicate pid: the remove must take the copy at the head.
    send_item(make_cmd(OP_PUSH_HEAD, 16'hFFFF));
    send_item(make_cmd(OP_PUSH_TAIL, 16'h0000));
    send_item(make_cmd(OP_PUSH_TAIL, 16'hFFFF));
    send_item(make_cmd(OP_REMOVE, 16'hFFFF));
    send_item(make_cmd(OP_POP_HEAD, 16'hFFFF));
    send_item(make_cmd(OP_POP_HEAD, 16'h0000));
    // Fill to capacity, then push at both ends of a full list.
    for (int i = 0; i < LIST_DEPTH; i++)
      send_item(make_cmd(OP_PUSH_TAIL,
                         (i == 3 || i == 9) ? 16'h5555 : (16'hA000 | PID_FIELD_W'(i))));
    send_item(make_cmd(OP_PUSH_HEAD, 16'h7777));
    send_item(make_cmd(OP_PUSH_TAIL, 16'h7777));
    // Remove from the middle of a full list, then a miss on a non-empty list.
    send_item(make_cmd(OP_REMOVE, 16'h5555));
    send_item(make_cmd(OP_REMOVE, 16'h1234));
    wait_drained();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      // Each segment leans toward filling, draining or neither.
      trend = $urandom_range(0, 2);
      quiet = (seg >= SEGMENTS - 2);
      source_idling = !quiet && $urandom_range(0, 3) != 0;
      sink_idling = !quiet && $urandom_range(0, 3) != 0;
      push_share = (trend == 0) ? 25 : (trend == 1) ? 40 : 65;
      pop_share = (trend == 0) ? 45 : (trend == 1) ? 30 : 15;
      if (seg == SEGMENTS / 2) wait_drained();
      repeat (SEG_ITEMS) begin
        roll = $urandom_range(0, 99);
        if (roll < push_share) op = $urandom_range(0, 1) ? OP_PUSH_HEAD : OP_PUSH_TAIL;
        else if (roll < push_share + pop_share) op = OP_POP_HEAD;
        else op = OP_REMOVE;
        // Removes often target a stored pid; the small pool makes duplicates common.
        if (op == OP_REMOVE && ledger.held_pids.size() != 0 && $urandom_range(0, 1) == 1)
          pid = ledger.held_pids[$urandom_range(0, ledger.held_pids.size() - 1)];
        else if ($urandom_range(0, 9) < 7)
          pid = pid_pool[$urandom_range(0, 5)];
        else
          pid = PID_FIELD_W'($urandom_range(0, 65535));
        send_item(make_cmd(op, pid));
      end
    end

    // Let the last results come back and the clock run on, then print the verdict.
    wait_drained();
    repeat (8) @(posedge clk);
    if (ledger.errors == 0)
      $display("pid_deque_with_remove verification clean");
    else
      $display("pid_deque_with_remove verification failed");
    $finish;
  end
endmodule

// ----- filelist.f -----
src/pdq_pkg.sv
src/pdq_cell.sv
src/pid_deque_with_remove.sv
src/pdq_checker.sv
verif/pid_deque_with_remove_tb.sv
